// ===== hdl/lpgs_pkg.sv =====
package lpgs_pkg;

	localparam int TIME_W    = 63;
	localparam int PERIOD_W  = 30;
	localparam int RANGE_W   = 36;
	localparam int MINLVL_W  = 16;
	localparam int CFG_W     = 36;
	localparam int CFG_IDX_W = 2;

	localparam logic [TIME_W-1:0]   TIME_MAX          = {TIME_W{1'b1}};
	localparam logic [PERIOD_W-1:0] PERIOD_RESET      = PERIOD_W'(1);
	localparam logic [RANGE_W-1:0]  MIN_RANGE_RESET   = '0;
	localparam logic [RANGE_W-1:0]  MAX_RANGE_RESET   = RANGE_W'(36'd51539607552);
	localparam logic [MINLVL_W-1:0] MIN_LEVEL_RESET   = '0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POINT_PERIOD = 2'd0,
		REG_MIN_RANGE_SQ = 2'd1,
		REG_MAX_RANGE_SQ = 2'd2,
		REG_MIN_LEVEL    = 2'd3
	} cfg_reg_t;

	typedef logic [TIME_W-1:0] time_ns_t;

	// timestamp unit results for the item leaving the input register
	typedef struct packed {
		time_ns_t stamp;
		time_ns_t head_prev;
	} stamp_info_t;

endpackage

// ===== hdl/lpgs_point_if.sv =====
interface lpgs_point_if #(
	parameter int COORD_BITS = 18,
	parameter int LEVEL_BITS = 16
) ();
	import lpgs_pkg::*;

	logic                         valid;
	logic                         ready;
	logic                         first_of_frame;
	logic [TIME_W-1:0]            frame_stamp;
	logic                         last_of_frame;
	logic signed [COORD_BITS-1:0] point_x;
	logic signed [COORD_BITS-1:0] point_y;
	logic signed [COORD_BITS-1:0] point_z;
	logic [LEVEL_BITS-1:0]        level;

	modport source (
		output valid, first_of_frame, frame_stamp, last_of_frame,
		output point_x, point_y, point_z, level,
		input  ready
	);

	modport sink (
		input  valid, first_of_frame, frame_stamp, last_of_frame,
		input  point_x, point_y, point_z, level,
		output ready
	);

endinterface

// ===== hdl/lpgs_result_if.sv =====
interface lpgs_result_if #(
	parameter int COORD_BITS = 18,
	parameter int LEVEL_BITS = 16
) ();
	import lpgs_pkg::*;

	logic                         valid;
	logic                         ready;
	logic [TIME_W-1:0]            out_time;
	logic signed [COORD_BITS-1:0] out_x;
	logic signed [COORD_BITS-1:0] out_y;
	logic signed [COORD_BITS-1:0] out_z;
	logic [LEVEL_BITS-1:0]        out_level;

	modport source (
		output valid, out_time, out_x, out_y, out_z, out_level,
		input  ready
	);

	modport sink (
		input  valid, out_time, out_x, out_y, out_z, out_level,
		output ready
	);

endinterface

// ===== hdl/lpgs_timer.sv =====
module lpgs_timer (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            step,
	input  logic                            first_of_frame,
	input  logic                            last_of_frame,
	input  lpgs_pkg::time_ns_t              frame_stamp,
	input  logic [lpgs_pkg::PERIOD_W-1:0]   period,
	output lpgs_pkg::stamp_info_t           info
);
	import lpgs_pkg::*;

	time_ns_t          running_q;
	time_ns_t          head_q;
	logic [TIME_W:0]   advanced;
	time_ns_t          stamp;

	always_comb begin
		advanced = {1'b0, running_q} + (TIME_W + 1)'(period);
		if (first_of_frame) begin
			stamp = frame_stamp;
		end else if (advanced[TIME_W]) begin
			stamp = TIME_MAX;
		end else begin
			stamp = advanced[TIME_W-1:0];
		end
	end

	assign info.stamp     = stamp;
	assign info.head_prev = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= '0;
			head_q    <= '0;
		end else if (step) begin
			running_q <= stamp;
			// head moves on the last point whether it is kept or not
			if (last_of_frame) begin
				head_q <= stamp;
			end
		end
	end

endmodule

// ===== hdl/lpgs_range_sq.sv =====
module lpgs_range_sq #(
	parameter int COORD_BITS = 18
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [COORD_BITS-1:0]  point_x,
	input  logic signed [COORD_BITS-1:0]  point_y,
	input  logic signed [COORD_BITS-1:0]  point_z,
	output logic [2*COORD_BITS+1:0]       dist_sq
);
	localparam int SQ_W  = 2 * COORD_BITS;
	localparam int SUM_W = SQ_W + 2;

	logic signed [SQ_W-1:0] prod_x, prod_y, prod_z;
	logic [SQ_W-1:0]        sq_x_s2, sq_y_s2, sq_z_s2;

	assign prod_x = point_x * point_x;
	assign prod_y = point_y * point_y;
	assign prod_z = point_z * point_z;

	always_ff @(posedge clk) begin
		if (en) begin
			sq_x_s2 <= SQ_W'(unsigned'(prod_x));
			sq_y_s2 <= SQ_W'(unsigned'(prod_y));
			sq_z_s2 <= SQ_W'(unsigned'(prod_z));
		end
	end

	assign dist_sq = SUM_W'(sq_x_s2) + SUM_W'(sq_y_s2) + SUM_W'(sq_z_s2);

endmodule

// ===== hdl/lidar_point_gate_and_stamp.sv =====
// Lidar point gate and time stamp.
// Points come in on the points channel, one transfer per point, with first and
// last frame flags; the first point of a frame carries the frame stamp. Each
// point gets a timestamp: the frame stamp on a first point, otherwise the
// previous timestamp plus point_period_ns, saturating at the 63-bit maximum.
// Kept points leave on the result channel with their timestamp; points with
// x of zero, low intensity, a stamp not after the previous frame's last stamp
// or a squared range outside [min_range_sq, max_range_sq] are dropped.
// Stages: input register, timestamp and square stage, sum and compare into the
// output register. One point per cycle is taken while the pipeline has room;
// the timestamp add and the squared-range sum set the stage lengths. Registers
// are to be written on the cfg port only while no point is in flight; the block
// does not enforce this. Reset clears the timestamps to zero, empties the
// pipeline and loads the register defaults. When the receiver stalls, the full
// stages hold and the input stalls only once every stage between is occupied.
module lidar_point_gate_and_stamp #(
	parameter int COORD_BITS = 18,
	parameter int LEVEL_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	lpgs_point_if.sink                         points,
	lpgs_result_if.source                      result,
	input  logic                               cfg_we,
	input  logic [lpgs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lpgs_pkg::CFG_W-1:0]         cfg_data
);
	import lpgs_pkg::*;

	localparam int SUM_W   = 2 * COORD_BITS + 2;
	localparam int CMP_W   = (SUM_W > RANGE_W) ? SUM_W : RANGE_W;
	localparam int LVL_CMP = (LEVEL_BITS > MINLVL_W) ? LEVEL_BITS : MINLVL_W;

	logic [PERIOD_W-1:0] period_q;
	logic [RANGE_W-1:0]  min_range_q;
	logic [RANGE_W-1:0]  max_range_q;
	logic [MINLVL_W-1:0] min_level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q    <= PERIOD_RESET;
			min_range_q <= MIN_RANGE_RESET;
			max_range_q <= MAX_RANGE_RESET;
			min_level_q <= MIN_LEVEL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_POINT_PERIOD: period_q    <= cfg_data[PERIOD_W-1:0];
				REG_MIN_RANGE_SQ: min_range_q <= cfg_data[RANGE_W-1:0];
				REG_MAX_RANGE_SQ: max_range_q <= cfg_data[RANGE_W-1:0];
				REG_MIN_LEVEL:    min_level_q <= cfg_data[MINLVL_W-1:0];
			endcase
		end
	end

	// pipeline control
	logic v_s1, v_s2, out_v_q;
	logic en1, en2, en3;
	logic keep;

	assign en3          = !out_v_q || result.ready;
	assign en2          = !v_s2 || en3;
	assign en1          = !v_s1 || en2;
	assign points.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= points.valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			// drop rejected points here
			if (en3) begin
				out_v_q <= v_s2 && keep;
			end
		end
	end

	// stage 1: input register
	logic                         first_s1, last_s1;
	time_ns_t                     stamp_s1;
	logic signed [COORD_BITS-1:0] x_s1, y_s1, z_s1;
	logic [LEVEL_BITS-1:0]        level_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			first_s1 <= points.first_of_frame;
			last_s1  <= points.last_of_frame;
			stamp_s1 <= points.frame_stamp;
			x_s1     <= points.point_x;
			y_s1     <= points.point_y;
			z_s1     <= points.point_z;
			level_s1 <= points.level;
		end
	end

	stamp_info_t stamp_info;

	lpgs_timer u_timer (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (v_s1 && en2),
		.first_of_frame (first_s1),
		.last_of_frame  (last_s1),
		.frame_stamp    (stamp_s1),
		.period         (period_q),
		.info           (stamp_info)
	);

	logic [SUM_W-1:0] dist_sq;

	lpgs_range_sq #(
		.COORD_BITS (COORD_BITS)
	) u_range_sq (
		.clk     (clk),
		.en      (en2),
		.point_x (x_s1),
		.point_y (y_s1),
		.point_z (z_s1),
		.dist_sq (dist_sq)
	);

	// stage 2: timestamp, head and squares
	time_ns_t                     time_s2, head_s2;
	logic signed [COORD_BITS-1:0] x_s2, y_s2, z_s2;
	logic [LEVEL_BITS-1:0]        level_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			time_s2  <= stamp_info.stamp;
			head_s2  <= stamp_info.head_prev;
			x_s2     <= x_s1;
			y_s2     <= y_s1;
			z_s2     <= z_s1;
			level_s2 <= level_s1;
		end
	end

	logic [CMP_W-1:0] dist_ext;
	logic             range_ok, level_ok, time_ok;

	always_comb begin
		dist_ext = CMP_W'(dist_sq);
		range_ok = (dist_ext >= CMP_W'(min_range_q)) && (dist_ext <= CMP_W'(max_range_q));
		level_ok = LVL_CMP'(level_s2) >= LVL_CMP'(min_level_q);
		time_ok  = time_s2 > head_s2;
		keep     = (x_s2 != '0) && level_ok && time_ok && range_ok;
	end

	// stage 3: output register
	always_ff @(posedge clk) begin
		if (en3) begin
			result.out_time  <= time_s2;
			result.out_x     <= x_s2;
			result.out_y     <= y_s2;
			result.out_z     <= z_s2;
			result.out_level <= level_s2;
		end
	end

	assign result.valid = out_v_q;

endmodule
